// File: src/chip8_execute_draw_unit_core_macros.svh
// Assertion helpers for the draw unit core.
// Both sample on clock and stay quiet while reset is high.
`ifndef CHIP8_EXECUTE_DRAW_UNIT_CORE_MACROS_SVH
`define CHIP8_EXECUTE_DRAW_UNIT_CORE_MACROS_SVH

// Same-cycle implication.
`define C8DU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c8du: check failed");

// Next-cycle implication.
`define C8DU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c8du: check failed");

`endif

// File: src/c8du_pkg.sv
package c8du_pkg;

   localparam int NUM_REGS = 16;
   localparam int REG_AW   = 4;

   localparam logic [REG_AW-1:0] VF_IDX     = 4'hF;
   localparam logic [11:0]       RAM_OFFSET = 12'd512;
   // nnn - RAM_OFFSET mod 4096 done as an add of the two's complement
   localparam logic [11:0]       JP_BIAS    = (~RAM_OFFSET) + 12'd1;
   localparam logic [15:0]       CLS_WORD   = 16'h00E0;

   typedef enum logic [3:0] {
      OP_SYS = 4'h0,
      OP_JP  = 4'h1,
      OP_LD  = 4'h6,
      OP_ADD = 4'h7,
      OP_LDI = 4'hA,
      OP_DRW = 4'hD
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_DONE   = 3'd0,
      KIND_CLS    = 3'd1,
      KIND_DRAW   = 3'd2,
      KIND_UNIMPL = 3'd3,
      KIND_TOGGLE = 3'd4
   } kind_type;

endpackage

// File: src/c8du_if.sv
interface c8du_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] instruction;
   logic [7:0]  sprite_row;
   logic [7:0]  pixels_were_on;

   modport source (output valid, action, instruction, sprite_row, pixels_were_on,
                   input ready);
   modport sink   (input valid, action, instruction, sprite_row, pixels_were_on,
                   output ready);
endinterface

interface c8du_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [8:0]  x_coord;
   logic [8:0]  y_coord;
   logic [11:0] sprite_address;
   logic [3:0]  row_count;
   logic [11:0] next_pc;
   logic        collision_flag;
   logic        last;

   modport source (output valid, kind, x_coord, y_coord, sprite_address, row_count,
                   next_pc, collision_flag, last, input ready);
   modport sink   (input valid, kind, x_coord, y_coord, sprite_address, row_count,
                   next_pc, collision_flag, last, output ready);
endinterface

// File: src/chip8_execute_draw_unit_core.sv
// CHIP-8 execute and draw core. Takes one request word at a time: either an
// instruction or a sprite row for the draw that the last DXYN opened. A small
// sequencer drives one shared 12-bit adder (PC step, JP target, ADD, pixel column,
// next draw row). An instruction passes from accept through PC step, execute and
// result, which waits for a free output register, before the next accept. A sprite
// row scans its bits from bit 7 down to its rightmost set bit, one bit position at a
// time, then steps the draw row; an empty row skips the scan and gives a result.
// A row with no draw pending goes straight to its result. Each toggle leaves through
// a one-deep output register, so a slow response side stalls the scan per toggle.
// The next request is taken while the final response word still waits.
`include "chip8_execute_draw_unit_core_macros.svh"

module chip8_execute_draw_unit_core (
   input  logic       clock,
   input  logic       reset,
   c8du_req_if.sink   req_ch,
   c8du_rsp_if.source rsp_ch
);
   import c8du_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_OP     = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_ROWEND = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   // control and architectural state
   state_type           state_ff, state_in;
   logic [7:0]          regs_ff [NUM_REGS];
   logic [7:0]          regs_in [NUM_REGS];
   logic [11:0]         pc_ff, pc_in;
   logic [11:0]         index_ff, index_in;
   logic [3:0]          rows_left_ff, rows_left_in;
   logic [REG_AW-1:0]   draw_x_idx_ff, draw_x_idx_in;
   logic [8:0]          draw_y_ff, draw_y_in;
   logic                out_valid_ff, out_valid_in;

   // payload
   logic                itm_action_ff, itm_action_in;
   logic [15:0]         itm_instr_ff, itm_instr_in;
   logic [7:0]          itm_row_ff, itm_row_in;
   logic [7:0]          itm_was_ff, itm_was_in;
   logic [7:0]          xbase_ff, xbase_in;
   logic [7:0]          scan_row_ff, scan_row_in;
   logic [7:0]          scan_was_ff, scan_was_in;
   logic [2:0]          offs_ff, offs_in;
   kind_type            res_kind_ff, res_kind_in;
   logic [3:0]          res_rows_ff, res_rows_in;
   kind_type            out_kind_ff, out_kind_in;
   logic [8:0]          out_x_ff, out_x_in;
   logic [8:0]          out_y_ff, out_y_in;
   logic [11:0]         out_addr_ff, out_addr_in;
   logic [3:0]          out_rows_ff, out_rows_in;
   logic [11:0]         out_pc_ff, out_pc_in;
   logic                out_flag_ff, out_flag_in;
   logic                out_last_ff, out_last_in;

   // shared adder and register file read port
   logic [11:0]         alu_a, alu_b, alu_sum;
   logic [REG_AW-1:0]   rd_addr;
   logic [7:0]          rd_data;
   logic                out_free;
   logic                out_load;

   opcode_type          op;
   logic [REG_AW-1:0]   ins_x, ins_y;
   logic [7:0]          ins_nn;
   logic [11:0]         ins_nnn;
   logic [3:0]          ins_n;

   assign op      = opcode_type'(itm_instr_ff[15:12]);
   assign ins_x   = itm_instr_ff[11:8];
   assign ins_y   = itm_instr_ff[7:4];
   assign ins_nn  = itm_instr_ff[7:0];
   assign ins_nnn = itm_instr_ff[11:0];
   assign ins_n   = itm_instr_ff[3:0];

   assign alu_sum  = alu_a + alu_b;
   assign rd_addr  = (state_ff == ST_OP) ? ((op == OP_DRW) ? ins_y : ins_x) : draw_x_idx_ff;
   assign rd_data  = regs_ff[rd_addr];
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      regs_in       = regs_ff;
      pc_in         = pc_ff;
      index_in      = index_ff;
      rows_left_in  = rows_left_ff;
      draw_x_idx_in = draw_x_idx_ff;
      draw_y_in     = draw_y_ff;
      itm_action_in = itm_action_ff;
      itm_instr_in  = itm_instr_ff;
      itm_row_in    = itm_row_ff;
      itm_was_in    = itm_was_ff;
      xbase_in      = xbase_ff;
      scan_row_in   = scan_row_ff;
      scan_was_in   = scan_was_ff;
      offs_in       = offs_ff;
      res_kind_in   = res_kind_ff;
      res_rows_in   = res_rows_ff;
      out_kind_in   = out_kind_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_addr_in   = out_addr_ff;
      out_rows_in   = out_rows_ff;
      out_pc_in     = out_pc_ff;
      out_flag_in   = out_flag_ff;
      out_last_in   = out_last_ff;
      out_load      = 1'b0;
      alu_a         = 12'd0;
      alu_b         = 12'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               itm_action_in = req_ch.action;
               itm_instr_in  = req_ch.instruction;
               itm_row_in    = req_ch.sprite_row;
               itm_was_in    = req_ch.pixels_were_on;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!itm_action_ff) begin
               // any instruction drops a pending draw
               alu_a        = pc_ff;
               alu_b        = 12'd2;
               pc_in        = alu_sum;
               rows_left_in = 4'd0;
               state_in     = ST_OP;
            end else if (rows_left_ff == 4'd0) begin
               res_kind_in = KIND_DONE;
               res_rows_in = 4'd0;
               state_in    = ST_RESULT;
            end else begin
               // Vx is sampled per row, so earlier collisions show through
               xbase_in    = rd_data;
               scan_row_in = itm_row_ff;
               scan_was_in = itm_was_ff;
               offs_in     = 3'd0;
               state_in    = (itm_row_ff == 8'd0) ? ST_ROWEND : ST_SCAN;
            end
         end
         ST_OP: begin
            res_kind_in = KIND_DONE;
            res_rows_in = 4'd0;
            state_in    = ST_RESULT;
            case (op)
               OP_SYS: begin
                  res_kind_in = (itm_instr_ff == CLS_WORD) ? KIND_CLS : KIND_UNIMPL;
               end
               OP_JP: begin
                  alu_a = ins_nnn;
                  alu_b = JP_BIAS;
                  pc_in = alu_sum;
               end
               OP_LD: begin
                  regs_in[ins_x] = ins_nn;
               end
               OP_ADD: begin
                  alu_a          = {4'd0, rd_data};
                  alu_b          = {4'd0, ins_nn};
                  regs_in[ins_x] = alu_sum[7:0];
               end
               OP_LDI: begin
                  index_in = ins_nnn;
               end
               OP_DRW: begin
                  // VF clears before VY is sampled
                  regs_in[VF_IDX] = 8'd0;
                  draw_y_in       = {1'b0, (ins_y == VF_IDX) ? 8'd0 : rd_data};
                  draw_x_idx_in   = ins_x;
                  rows_left_in    = ins_n;
                  res_kind_in     = KIND_DRAW;
                  res_rows_in     = ins_n;
               end
               default: begin
                  res_kind_in = KIND_UNIMPL;
               end
            endcase
         end
         ST_SCAN: begin
            // bit 7 of the shifted row is the current pixel, offs_ff its column offset from Vx
            alu_a = {4'd0, xbase_ff};
            alu_b = {9'd0, offs_ff};
            if (!scan_row_ff[7] || out_free) begin
               if (scan_row_ff[7]) begin
                  out_load    = 1'b1;
                  out_kind_in = KIND_TOGGLE;
                  out_x_in    = alu_sum[8:0];
                  out_y_in    = draw_y_ff;
                  out_addr_in = index_ff;
                  out_rows_in = 4'd0;
                  out_pc_in   = pc_ff;
                  out_flag_in = regs_ff[VF_IDX][0] | scan_was_ff[7];
                  out_last_in = (scan_row_ff[6:0] == 7'd0);
                  if (scan_was_ff[7]) begin
                     regs_in[VF_IDX] = 8'd1;
                  end
               end
               scan_row_in = {scan_row_ff[6:0], 1'b0};
               scan_was_in = {scan_was_ff[6:0], 1'b0};
               offs_in     = offs_ff + 3'd1;
               if (scan_row_ff[6:0] == 7'd0) begin
                  state_in = ST_ROWEND;
               end
            end
         end
         ST_ROWEND: begin
            alu_a        = {3'd0, draw_y_ff};
            alu_b        = 12'd1;
            draw_y_in    = alu_sum[8:0];
            rows_left_in = rows_left_ff - 4'd1;
            if (itm_row_ff == 8'd0) begin
               res_kind_in = KIND_DONE;
               res_rows_in = 4'd0;
               state_in    = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = res_kind_ff;
               out_x_in    = 9'd0;
               out_y_in    = 9'd0;
               out_addr_in = index_ff;
               out_rows_in = res_rows_ff;
               out_pc_in   = pc_ff;
               out_flag_in = regs_ff[VF_IDX][0];
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         pc_ff         <= 12'd0;
         index_ff      <= 12'd0;
         rows_left_ff  <= 4'd0;
         draw_x_idx_ff <= '0;
         draw_y_ff     <= 9'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         regs_ff       <= regs_in;
         pc_ff         <= pc_in;
         index_ff      <= index_in;
         rows_left_ff  <= rows_left_in;
         draw_x_idx_ff <= draw_x_idx_in;
         draw_y_ff     <= draw_y_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      itm_action_ff <= itm_action_in;
      itm_instr_ff  <= itm_instr_in;
      itm_row_ff    <= itm_row_in;
      itm_was_ff    <= itm_was_in;
      xbase_ff      <= xbase_in;
      scan_row_ff   <= scan_row_in;
      scan_was_ff   <= scan_was_in;
      offs_ff       <= offs_in;
      res_kind_ff   <= res_kind_in;
      res_rows_ff   <= res_rows_in;
      out_kind_ff   <= out_kind_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_addr_ff   <= out_addr_in;
      out_rows_ff   <= out_rows_in;
      out_pc_ff     <= out_pc_in;
      out_flag_ff   <= out_flag_in;
      out_last_ff   <= out_last_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_kind_ff;
   assign rsp_ch.x_coord        = out_x_ff;
   assign rsp_ch.y_coord        = out_y_ff;
   assign rsp_ch.sprite_address = out_addr_ff;
   assign rsp_ch.row_count      = out_rows_ff;
   assign rsp_ch.next_pc        = out_pc_ff;
   assign rsp_ch.collision_flag = out_flag_ff;
   assign rsp_ch.last           = out_last_ff;

   // a loaded word never overwrites one the sink has not taken
   `C8DU_ASSERT_IMPL(a_load_when_free, out_load, (!out_valid_ff || rsp_ch.ready))
   // scanning only happens inside an open draw
   `C8DU_ASSERT_IMPL(a_scan_needs_draw, (state_ff == ST_SCAN), (rows_left_ff != 4'd0))
   // one request word at a time
   `C8DU_ASSERT_NEXT(a_busy_after_accept, (req_ch.valid && req_ch.ready), !req_ch.ready)

endmodule
